@@ hw/rtl/esa_pkg.sv @@
// Package for the ascending exchange sort block.
// Holds the item types, sizing constants, sequencer states and control structs.
// No dependencies.
package esa_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned DataW    = 32;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    final_res;
    logic                    overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StSortRead,
    StSortLoad,
    StCompare,
    StWriteBack,
    StEmitRead,
    StEmitLoad,
    StEmitWait
  } state_e;

  typedef enum logic {
    WselInput,
    WselCurrent
  } wsel_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    wsel_e            wsel;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_cmd_t;

  typedef struct packed {
    logic cur_load;
    logic out_load;
    logic out_last;
    logic out_ovf;
  } dp_ctrl_t;

endpackage

@@ hw/rtl/esa_store.sv @@
// Element store of the exchange sort: one write port and one registered read port.
// Depends on esa_pkg.
module esa_store (
  input  logic                         clk_i,
  input  esa_pkg::mem_cmd_t            mem_cmd_i,
  input  logic [esa_pkg::DataW-1:0]    wdata_i,
  output logic [esa_pkg::DataW-1:0]    rdata_o
);

  logic [esa_pkg::DataW-1:0] mem_q [esa_pkg::Capacity];
  logic [esa_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_cmd_i.we) begin
      mem_q[mem_cmd_i.waddr] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_cmd_i.re) begin
      rdata_q <= mem_q[mem_cmd_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/esa_ctrl.sv @@
// Sequencer of the exchange sort: loading, the compare and swap passes and emission.
// Depends on esa_pkg.
module esa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  logic              greater_i,
  input  logic              out_fire_i,
  output esa_pkg::mem_cmd_t mem_cmd_o,
  output esa_pkg::dp_ctrl_t dp_ctrl_o
);

  localparam int unsigned CountW = esa_pkg::CountW;
  localparam int unsigned AddrW  = esa_pkg::AddrW;

  esa_pkg::state_e   state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic              dropped_q, dropped_d;
  logic [AddrW-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic [CountW-1:0] i_nx, j_nx, k_nx;

  assign i_nx = {1'b0, i_q} + CountW'(1);
  assign j_nx = {1'b0, j_q} + CountW'(1);
  assign k_nx = {1'b0, k_q} + CountW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= esa_pkg::StIdle;
      count_q   <= '0;
      dropped_q <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    count_d          = count_q;
    dropped_d        = dropped_q;
    i_d              = i_q;
    j_d              = j_q;
    k_d              = k_q;
    in_ready_o       = 1'b0;
    mem_cmd_o.we     = 1'b0;
    mem_cmd_o.waddr  = '0;
    mem_cmd_o.wsel   = esa_pkg::WselInput;
    mem_cmd_o.re     = 1'b0;
    mem_cmd_o.raddr  = '0;
    dp_ctrl_o.cur_load = 1'b0;
    dp_ctrl_o.out_load = 1'b0;
    dp_ctrl_o.out_last = (k_nx == count_q);
    dp_ctrl_o.out_ovf  = dropped_q;

    case (state_q)
      esa_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (count_q < CountW'(esa_pkg::Capacity)) begin
            mem_cmd_o.we    = 1'b1;
            mem_cmd_o.waddr = count_q[AddrW-1:0];
            mem_cmd_o.wsel  = esa_pkg::WselInput;
            count_d         = count_q + CountW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (in_last_i) begin
            i_d = '0;
            k_d = '0;
            if (count_d == CountW'(1)) begin
              state_d = esa_pkg::StEmitRead;
            end else begin
              state_d = esa_pkg::StSortRead;
            end
          end
        end
      end
      esa_pkg::StSortRead: begin
        mem_cmd_o.re    = 1'b1;
        mem_cmd_o.raddr = i_q;
        state_d         = esa_pkg::StSortLoad;
      end
      esa_pkg::StSortLoad: begin
        dp_ctrl_o.cur_load = 1'b1;
        mem_cmd_o.re       = 1'b1;
        mem_cmd_o.raddr    = i_nx[AddrW-1:0];
        j_d                = i_nx[AddrW-1:0];
        state_d            = esa_pkg::StCompare;
      end
      esa_pkg::StCompare: begin
        if (greater_i) begin
          dp_ctrl_o.cur_load = 1'b1;
          mem_cmd_o.we       = 1'b1;
          mem_cmd_o.waddr    = j_q;
          mem_cmd_o.wsel     = esa_pkg::WselCurrent;
        end
        if (j_nx < count_q) begin
          mem_cmd_o.re    = 1'b1;
          mem_cmd_o.raddr = j_nx[AddrW-1:0];
          j_d             = j_nx[AddrW-1:0];
        end else begin
          state_d = esa_pkg::StWriteBack;
        end
      end
      esa_pkg::StWriteBack: begin
        mem_cmd_o.we    = 1'b1;
        mem_cmd_o.waddr = i_q;
        mem_cmd_o.wsel  = esa_pkg::WselCurrent;
        i_d             = i_nx[AddrW-1:0];
        if (i_nx + CountW'(1) == count_q) begin
          k_d     = '0;
          state_d = esa_pkg::StEmitRead;
        end else begin
          mem_cmd_o.re    = 1'b1;
          mem_cmd_o.raddr = i_nx[AddrW-1:0];
          state_d         = esa_pkg::StSortLoad;
        end
      end
      esa_pkg::StEmitRead: begin
        mem_cmd_o.re    = 1'b1;
        mem_cmd_o.raddr = k_q;
        state_d         = esa_pkg::StEmitLoad;
      end
      esa_pkg::StEmitLoad: begin
        dp_ctrl_o.out_load = 1'b1;
        state_d            = esa_pkg::StEmitWait;
      end
      esa_pkg::StEmitWait: begin
        if (out_fire_i) begin
          if (k_nx == count_q) begin
            count_d   = '0;
            dropped_d = 1'b0;
            state_d   = esa_pkg::StIdle;
          end else begin
            k_d     = k_nx[AddrW-1:0];
            state_d = esa_pkg::StEmitRead;
          end
        end
      end
      default: begin
        state_d = esa_pkg::StIdle;
      end
    endcase
  end

  // The stored count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(esa_pkg::Capacity))
  else $error("element count beyond capacity");

  // During a pass the inner index always lies beyond the outer one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == esa_pkg::StCompare |-> (j_q > i_q) && (j_nx <= count_q))
  else $error("compare index out of range");

  // A write and a read in the same cycle never target the same entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_cmd_o.we && mem_cmd_o.re) |-> mem_cmd_o.waddr != mem_cmd_o.raddr)
  else $error("store read and write collide");

  // An item leaves only while the sequencer waits for it to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire_i |-> state_q == esa_pkg::StEmitWait)
  else $error("output item taken outside emission");

endmodule

@@ hw/rtl/exchange_sort_ascending.sv @@
// Top level of the ascending exchange sort: datapath, compare unit and output register.
// Depends on esa_pkg, esa_store and esa_ctrl.
//
// Usage: input items (value, last) arrive on in_valid_i / in_ready_o / in_data_i.
// Each item is stored as it is accepted; up to Capacity (64) elements are kept and
// any further element of the set is dropped, which sets overflow on every result.
// The item with last set closes the set, even if it was itself dropped.
// The block then sorts the set with a single shared signed comparator, one
// compare per cycle: N*(N-1)/2 compares plus a load and a write-back per outer pass.
// During sorting and emission in_ready_o stays low.
// Results leave on out_valid_o / out_ready_i / out_data_o one at a time; the next is
// read only after the previous is taken; the final result of a set carries final_res.
// A stalled receiver simply holds the output register; nothing is lost.
// After the last result is taken the block is ready for the next set.
// A set of a single element skips sorting and goes straight to emission.
// Reset empties the set, clears the overflow flag and returns to loading.
module exchange_sort_ascending (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  esa_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output esa_pkg::out_item_t out_data_o
);

  esa_pkg::mem_cmd_t          mem_cmd;
  esa_pkg::dp_ctrl_t          dp_ctrl;
  logic [esa_pkg::DataW-1:0]  rdata;
  logic [esa_pkg::DataW-1:0]  wdata;
  logic [esa_pkg::DataW-1:0]  cur_q;
  logic                       greater;
  logic                       out_fire;
  logic                       out_valid_q;
  esa_pkg::out_item_t         out_q;

  assign greater  = $signed(cur_q) > $signed(rdata);
  assign out_fire = out_valid_q && out_ready_i;
  assign wdata    = (mem_cmd.wsel == esa_pkg::WselCurrent) ? cur_q : in_data_i.value;

  esa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last),
    .in_ready_o (in_ready_o),
    .greater_i  (greater),
    .out_fire_i (out_fire),
    .mem_cmd_o  (mem_cmd),
    .dp_ctrl_o  (dp_ctrl)
  );

  esa_store u_store (
    .clk_i     (clk_i),
    .mem_cmd_i (mem_cmd),
    .wdata_i   (wdata),
    .rdata_o   (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (dp_ctrl.cur_load) begin
      cur_q <= rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (dp_ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_ctrl.out_load) begin
      out_q.sorted_value <= $signed(rdata);
      out_q.final_res    <= dp_ctrl.out_last;
      out_q.overflow     <= dp_ctrl.out_ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Loading and emission never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_ready_o)
  else $error("input accepted while a result is pending");

  // A new result is never loaded over one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_ctrl.out_load |-> !out_valid_q)
  else $error("output register overwritten");

endmodule
